>>> src/dda_line_rasterizer_defines.svh
// ----------------------------------------------------------------------------
// DDA line rasterizer assertion macros
// Shared assertion forms for the rasterizer modules. Each macro expects the
// signals clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dda_pkg.sv
// ----------------------------------------------------------------------------
// DDA rasterizer package
// Operation codes, the sequencer state type and the divider status bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dda_pkg;

  // Operation codes carried in the func field of an input item.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Sequencer states of the top level.
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DIVIDE
  } dda_state_t;

  // Status reported by the slope divider.
  typedef struct packed {
    logic busy;
    logic done;
  } dda_div_sts_t;

endpackage

>>> src/dda_in_if.sv
// ----------------------------------------------------------------------------
// DDA rasterizer input channel
// Valid/ready channel that carries one command item: start or step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dda_in_if #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (
    output valid, func, x_start, y_start, x_end, y_end,
    input  ready
  );

  modport sink (
    input  valid, func, x_start, y_start, x_end, y_end,
    output ready
  );
endinterface

>>> src/dda_out_if.sv
// ----------------------------------------------------------------------------
// DDA rasterizer result channel
// Valid/ready channel that carries one pixel item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dda_out_if #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  pixel_valid;
  logic                  last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_valid, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_valid, last,
    output ready
  );
endinterface

>>> src/dda_div.sv
// ----------------------------------------------------------------------------
// DDA slope divider
// Restoring divider that produces one quotient bit per cycle. The dividend
// must not exceed the divisor, so the quotient is at most one in fixed point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dda_line_rasterizer_defines.svh"

module dda_div
  import dda_pkg::*;
#(
  parameter int DIV_BITS = 12,
  parameter int QUO_BITS = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0] divisor,
  output logic [QUO_BITS-1:0] quotient,
  output dda_div_sts_t        sts
);

  localparam int CNT_BITS = $clog2(QUO_BITS);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [DIV_BITS:0]   rem_r, rem_nxt;
  logic [DIV_BITS-1:0] den_r, den_nxt;
  logic [QUO_BITS-1:0] quo_r, quo_nxt;
  logic                ge;
  logic [DIV_BITS:0]   diff;

  // One compare and subtract per cycle; the partial remainder stays below
  // twice the divisor, so it fits one bit above the divisor width.
  always_comb begin
    ge       = rem_r >= {1'b0, den_r};
    diff     = rem_r - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(QUO_BITS - 1);
      rem_nxt  = {1'b0, dividend};
      den_nxt  = divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[QUO_BITS-2:0], ge};
      if (ge) begin
        rem_nxt = {diff[DIV_BITS-1:0], 1'b0};
      end else begin
        rem_nxt = {rem_r[DIV_BITS-1:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control flags are reset; the datapath needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

  `DDA_ASSERT_SAME(a_start_not_busy, start, !busy_r, "Divider started while busy.")
  `DDA_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "Divider done held for two cycles.")
  `DDA_ASSERT_SAME(a_quo_le_one, done_r && quo_r[QUO_BITS-1], quo_r[QUO_BITS-2:0] == '0,
    "Slope quotient exceeds one.")

endmodule

>>> src/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Walks a line one pixel per step item along its major axis, adding a
// fixed-point slope to the minor coordinate. The slope comes from a
// bit-serial divider that runs after each start item of nonzero length.
//
//   Channel   Direction  Carries
//   in_ch     sink       func, x_start, y_start, x_end, y_end
//   out_ch    source     pixel_x, pixel_y, pixel_valid, last
//
// A step item's pixel is registered at the accept edge. A start item of
// nonzero length registers its start pixel the same way and starts the
// divider; when the divider reports done, the slope is registered and the
// sequencer returns to idle. A zero-length start does not use the divider.
// Input ready is low while the divider runs and while a pixel waits unread.
// Reset is synchronous and clears the state, the active line and output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dda_line_rasterizer_defines.svh"

module dda_line_rasterizer
  import dda_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dda_in_if.sink    in_ch,
  dda_out_if.source out_ch
);

  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS;
  localparam int SLOPE_BITS = FRAC_BITS + 1;
  localparam logic [FRAC_BITS-1:0] HALF_LSB = FRAC_BITS'(1) << (FRAC_BITS - 1);

  dda_state_t state_r, state_nxt;

  logic                  line_active_r, line_active_nxt;
  logic                  major_is_y_r, major_is_y_nxt;
  logic [COORD_BITS-1:0] major_pos_r, major_pos_nxt;
  logic [COORD_BITS-1:0] major_end_r, major_end_nxt;
  logic                  major_down_r, major_down_nxt;
  // The accumulator holds the minor position plus one half, so its integer
  // bits are already the half-up rounded coordinate.
  logic [ACC_BITS-1:0]   minor_accum_r, minor_accum_nxt;
  logic                  minor_down_r, minor_down_nxt;
  logic [SLOPE_BITS-1:0] slope_frac_r, slope_frac_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] pixel_x_r, pixel_x_nxt;
  logic [COORD_BITS-1:0] pixel_y_r, pixel_y_nxt;
  logic                  pixel_valid_r, pixel_valid_nxt;
  logic                  last_r, last_nxt;

  logic                  in_accept;
  logic                  div_start;
  logic [SLOPE_BITS-1:0] div_quo;
  dda_div_sts_t          div_sts;

  // Start decode signals.
  logic [COORD_BITS-1:0] dx, dy, s_pos, s_end, s_min, d_maj, d_min;
  logic                  s_maj_y, s_maj_down, s_min_down, s_last;

  // Step datapath signals.
  logic [COORD_BITS-1:0] step_pos, step_min;
  logic [ACC_BITS-1:0]   step_acc;
  logic                  step_last;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_accept   = in_ch.valid && in_ch.ready;

  // Pick the major axis and order the spans for a start item.
  always_comb begin
    dx         = (in_ch.x_end >= in_ch.x_start) ? in_ch.x_end - in_ch.x_start
                                                : in_ch.x_start - in_ch.x_end;
    dy         = (in_ch.y_end >= in_ch.y_start) ? in_ch.y_end - in_ch.y_start
                                                : in_ch.y_start - in_ch.y_end;
    s_maj_y    = dy > dx;
    s_pos      = s_maj_y ? in_ch.y_start : in_ch.x_start;
    s_end      = s_maj_y ? in_ch.y_end   : in_ch.x_end;
    s_min      = s_maj_y ? in_ch.x_start : in_ch.y_start;
    s_maj_down = s_maj_y ? (in_ch.y_end < in_ch.y_start) : (in_ch.x_end < in_ch.x_start);
    s_min_down = s_maj_y ? (in_ch.x_end < in_ch.x_start) : (in_ch.y_end < in_ch.y_start);
    d_maj      = s_maj_y ? dy : dx;
    d_min      = s_maj_y ? dx : dy;
    s_last     = s_pos == s_end;
  end

  // Advance one pixel along the major axis.
  always_comb begin
    step_pos  = major_down_r ? major_pos_r - COORD_BITS'(1) : major_pos_r + COORD_BITS'(1);
    step_acc  = minor_down_r ? minor_accum_r - ACC_BITS'(slope_frac_r)
                             : minor_accum_r + ACC_BITS'(slope_frac_r);
    step_min  = step_acc[ACC_BITS-1:FRAC_BITS];
    step_last = step_pos == major_end_r;
  end

  assign div_start = in_accept && (in_ch.func == FUNC_START) && !s_last;

  dda_div #(
    .DIV_BITS (COORD_BITS),
    .QUO_BITS (SLOPE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (d_min),
    .divisor  (d_maj),
    .quotient (div_quo),
    .sts      (div_sts)
  );

  // Sequencer: next state, line state and output register.
  always_comb begin
    state_nxt       = state_r;
    line_active_nxt = line_active_r;
    major_is_y_nxt  = major_is_y_r;
    major_pos_nxt   = major_pos_r;
    major_end_nxt   = major_end_r;
    major_down_nxt  = major_down_r;
    minor_accum_nxt = minor_accum_r;
    minor_down_nxt  = minor_down_r;
    slope_frac_nxt  = slope_frac_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    pixel_x_nxt     = pixel_x_r;
    pixel_y_nxt     = pixel_y_r;
    pixel_valid_nxt = pixel_valid_r;
    last_nxt        = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          out_valid_nxt = 1'b1;
          if (in_ch.func == FUNC_START) begin
            // New line: latch geometry and emit the start pixel.
            major_is_y_nxt  = s_maj_y;
            major_pos_nxt   = s_pos;
            major_end_nxt   = s_end;
            major_down_nxt  = s_maj_down;
            minor_down_nxt  = s_min_down;
            minor_accum_nxt = {s_min, HALF_LSB};
            slope_frac_nxt  = '0;
            line_active_nxt = !s_last;
            pixel_x_nxt     = s_maj_y ? s_min : s_pos;
            pixel_y_nxt     = s_maj_y ? s_pos : s_min;
            pixel_valid_nxt = 1'b1;
            last_nxt        = s_last;
            if (!s_last) begin
              state_nxt = ST_DIVIDE;
            end
          end else if (line_active_r) begin
            major_pos_nxt   = step_pos;
            minor_accum_nxt = step_acc;
            line_active_nxt = !step_last;
            pixel_x_nxt     = major_is_y_r ? step_min : step_pos;
            pixel_y_nxt     = major_is_y_r ? step_pos : step_min;
            pixel_valid_nxt = 1'b1;
            last_nxt        = step_last;
          end else begin
            // Step without an active line gives an empty item.
            pixel_x_nxt     = '0;
            pixel_y_nxt     = '0;
            pixel_valid_nxt = 1'b0;
            last_nxt        = 1'b0;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_sts.done) begin
          slope_frac_nxt = div_quo;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state is reset; geometry and pixel payload are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      line_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      line_active_r <= line_active_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    major_is_y_r  <= major_is_y_nxt;
    major_pos_r   <= major_pos_nxt;
    major_end_r   <= major_end_nxt;
    major_down_r  <= major_down_nxt;
    minor_accum_r <= minor_accum_nxt;
    minor_down_r  <= minor_down_nxt;
    slope_frac_r  <= slope_frac_nxt;
    pixel_x_r     <= pixel_x_nxt;
    pixel_y_r     <= pixel_y_nxt;
    pixel_valid_r <= pixel_valid_nxt;
    last_r        <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = pixel_x_r;
  assign out_ch.pixel_y     = pixel_y_r;
  assign out_ch.pixel_valid = pixel_valid_r;
  assign out_ch.last        = last_r;

  `DDA_ASSERT_SAME(a_ready_idle, in_ch.ready, state_r == ST_IDLE,
    "Input ready outside the idle state.")
  `DDA_ASSERT_SAME(a_done_in_divide, div_sts.done, state_r == ST_DIVIDE,
    "Divider finished outside the divide state.")
  `DDA_ASSERT_NEXT(a_idle_step_empty,
    in_accept && (in_ch.func == FUNC_STEP) && !line_active_r,
    out_valid_r && !pixel_valid_r && !last_r,
    "Step without a line produced a pixel.")
  `DDA_ASSERT_SAME(a_last_ends_line, out_valid_r && pixel_valid_r && last_r, !line_active_r,
    "Line still active after its last pixel.")

endmodule

>>> verif/dda_line_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer testbench
// Sends start and step items to the rasterizer and checks every pixel item
// against a predictor that runs the same fixed-point line walk. The directed
// tests cover the corners, a long receiver hold-off and random line sequences.
// Random idling happens on both channels, and the final stretch runs without it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_line_rasterizer_tb;
  import dda_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS;
  localparam int RAND_ITEMS = 1650;
  localparam int TOTAL_ITEMS = 1750;
  localparam int DRAIN_CYCLES = 40;

  // One input item as the sender drives it.
  typedef struct packed {
    logic                  func;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } line_cmd_t;

  // One pixel item as the block should emit it.
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  pixel_valid;
    logic                  last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;

  dda_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
  dda_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

  dda_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  // Predicted line state.
  logic                  ln_active;
  logic                  ln_major_y;
  logic                  ln_major_down;
  logic                  ln_minor_down;
  logic [COORD_BITS-1:0] ln_major_pos;
  logic [COORD_BITS-1:0] ln_major_end;
  logic [ACC_BITS-1:0]   ln_accum;
  logic [FRAC_BITS:0]    ln_slope;

  pixel_t pixel_q[$];
  int     err_count  = 0;
  int     items_sent = 0;
  bit     idle_on    = 1'b1;
  int     hold_req   = 0;
  int     hold_left  = 0;
  int     stall_left = 0;

  // Advances the predicted line by one item and returns the pixel it yields.
  function automatic pixel_t rasterize(input line_cmd_t c);
    pixel_t                 p;
    logic [COORD_BITS-1:0]  dx, dy, dmaj, dmin, minor0, mn;
    logic [ACC_BITS-1:0]    quo, rounded;
    logic                   at_end;
    p = '0;
    at_end = 1'b0;
    if (c.func == FUNC_START) begin
      dx = (c.x_end >= c.x_start) ? c.x_end - c.x_start : c.x_start - c.x_end;
      dy = (c.y_end >= c.y_start) ? c.y_end - c.y_start : c.y_start - c.y_end;
      ln_major_y = dy > dx;
      if (ln_major_y) begin
        ln_major_pos  = c.y_start;
        ln_major_end  = c.y_end;
        ln_major_down = c.y_end < c.y_start;
        minor0        = c.x_start;
        ln_minor_down = c.x_end < c.x_start;
        dmaj = dy;
        dmin = dx;
      end else begin
        ln_major_pos  = c.x_start;
        ln_major_end  = c.x_end;
        ln_major_down = c.x_end < c.x_start;
        minor0        = c.y_start;
        ln_minor_down = c.y_end < c.y_start;
        dmaj = dx;
        dmin = dy;
      end
      // Truncated slope; it never exceeds 1.0 since the minor span is never larger.
      quo = (dmaj == '0) ? '0 : {dmin, {FRAC_BITS{1'b0}}} / ACC_BITS'(dmaj);
      ln_slope  = quo[FRAC_BITS:0];
      ln_accum  = {minor0, {FRAC_BITS{1'b0}}};
      at_end    = ln_major_pos == ln_major_end;
      ln_active = !at_end;
      p.pixel_valid = 1'b1;
    end else if (ln_active) begin
      ln_major_pos = ln_major_down ? ln_major_pos - COORD_BITS'(1)
                                   : ln_major_pos + COORD_BITS'(1);
      ln_accum = ln_minor_down ? ln_accum - ACC_BITS'(ln_slope)
                               : ln_accum + ACC_BITS'(ln_slope);
      at_end = ln_major_pos == ln_major_end;
      if (at_end) ln_active = 1'b0;
      p.pixel_valid = 1'b1;
    end
    // Pixels are only formed for an active or newly started line.
    if (p.pixel_valid) begin
      rounded = ln_accum + (ACC_BITS'(1) << (FRAC_BITS - 1));
      mn = rounded[ACC_BITS-1:FRAC_BITS];
      p.pixel_x = ln_major_y ? mn : ln_major_pos;
      p.pixel_y = ln_major_y ? ln_major_pos : mn;
      p.last    = at_end;
    end
    return p;
  endfunction

  // Picks a coordinate, with the edges of the range favored.
  function automatic int coord_pick();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r == 1) return COORD_MAX;
    return $urandom_range(0, COORD_MAX);
  endfunction

  // Places an end point at the given span from the start, inside the range.
  function automatic int end_point(input int s, input int span);
    if ($urandom_range(0, 1) && s + span <= COORD_MAX) return s + span;
    if (s >= span) return s - span;
    return s + span;
  endfunction

  // Offers one item and records its expected pixel once it is accepted.
  task automatic send_item(input line_cmd_t c);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.func    <= c.func;
    in_ch.x_start <= c.x_start;
    in_ch.y_start <= c.y_start;
    in_ch.x_end   <= c.x_end;
    in_ch.y_end   <= c.y_end;
    do @(posedge clk); while (!in_ch.ready);
    pixel_q.push_back(rasterize(c));
    items_sent++;
  endtask

  // A step item carries junk in its coordinate fields, which must be ignored.
  task automatic send_step();
    line_cmd_t c;
    c.func    = FUNC_STEP;
    c.x_start = COORD_BITS'($urandom);
    c.y_start = COORD_BITS'($urandom);
    c.x_end   = COORD_BITS'($urandom);
    c.y_end   = COORD_BITS'($urandom);
    send_item(c);
  endtask

  task automatic draw_line(input int xs, input int ys, input int xe, input int ye,
                           input int steps);
    line_cmd_t c;
    c.func    = FUNC_START;
    c.x_start = COORD_BITS'(xs);
    c.y_start = COORD_BITS'(ys);
    c.x_end   = COORD_BITS'(xe);
    c.y_end   = COORD_BITS'(ye);
    send_item(c);
    repeat (steps) send_step();
  endtask

  // A step right after reset finds no line and must yield an invalid pixel.
  task automatic test_step_without_line();
    send_step();
  endtask

  task automatic test_zero_length();
    draw_line(0, 0, 0, 0, 0);
    draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
  endtask

  // Diagonal tie, shallow and steep lines toward both ends of the range.
  task automatic test_octants();
    draw_line(10, 10, 12, 12, 2);
    draw_line(0, COORD_MAX, 3, COORD_MAX - 2, 3);
    draw_line(COORD_MAX, 0, COORD_MAX - 2, 3, 3);
    // The line has ended, so this step finds nothing to draw.
    send_step();
  endtask

  // A new start drops the line in flight.
  task automatic test_restart();
    draw_line(100, 100, 200, 150, 1);
    draw_line(5, 5, 5, 7, 2);
  endtask

  // The receiver holds off while steps keep coming, so the block backs up.
  task automatic test_backpressure();
    draw_line(300, 400, 260, 371, 0);
    hold_req = 150;
    repeat (40) send_step();
  endtask

  // Mostly complete lines with random geometry, plus stray steps and cut lines.
  // Idling is drawn per line only when allow_idle is set.
  task automatic test_random_lines(input int item_goal, input bit allow_idle);
    int kind, span_maj, span_min, xs, ys, xe, ye, steps;
    while (items_sent < item_goal) begin
      idle_on = allow_idle && ($urandom_range(0, 4) != 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 3)) send_step();
      end else begin
        span_maj = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300)
                                                : $urandom_range(0, 24);
        span_min = $urandom_range(0, span_maj);
        xs = coord_pick();
        ys = coord_pick();
        if ($urandom_range(0, 1)) begin
          xe = end_point(xs, span_maj);
          ye = end_point(ys, span_min);
        end else begin
          xe = end_point(xs, span_min);
          ye = end_point(ys, span_maj);
        end
        if (kind == 1) begin
          steps = (span_maj > 0) ? $urandom_range(0, span_maj - 1) : 0;
        end else begin
          steps = span_maj + (($urandom_range(0, 5) == 0) ? 1 : 0);
        end
        draw_line(xs, ys, xe, ye, steps);
      end
    end
  endtask

  // Receiver ready: long hold-offs on request, short random stalls otherwise.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted pixel item with the oldest expectation.
  always @(posedge clk) begin
    pixel_t exp_pix;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel item x=%0d y=%0d valid=%0d last=%0d", $time,
                 out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_valid, out_ch.last);
        err_count++;
      end else begin
        exp_pix = pixel_q.pop_front();
        if (out_ch.pixel_x !== exp_pix.pixel_x) begin
          $display("%0t: pixel_x expected %0d, got %0d", $time,
                   exp_pix.pixel_x, out_ch.pixel_x);
          err_count++;
        end
        if (out_ch.pixel_y !== exp_pix.pixel_y) begin
          $display("%0t: pixel_y expected %0d, got %0d", $time,
                   exp_pix.pixel_y, out_ch.pixel_y);
          err_count++;
        end
        if (out_ch.pixel_valid !== exp_pix.pixel_valid) begin
          $display("%0t: pixel_valid expected %0d, got %0d", $time,
                   exp_pix.pixel_valid, out_ch.pixel_valid);
          err_count++;
        end
        if (out_ch.last !== exp_pix.last) begin
          $display("%0t: last expected %0d, got %0d", $time,
                   exp_pix.last, out_ch.last);
          err_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_START;
    in_ch.x_start = '0;
    in_ch.y_start = '0;
    in_ch.x_end   = '0;
    in_ch.y_end   = '0;
    ln_active     = 1'b0;
    ln_major_y    = 1'b0;
    ln_major_down = 1'b0;
    ln_minor_down = 1'b0;
    ln_major_pos  = '0;
    ln_major_end  = '0;
    ln_accum      = '0;
    ln_slope      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_step_without_line();
    test_zero_length();
    test_octants();
    test_restart();
    test_backpressure();
    test_random_lines(RAND_ITEMS, 1'b1);
    // Final stretch at full rate on both sides.
    idle_on = 1'b0;
    test_random_lines(TOTAL_ITEMS, 1'b0);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pixel_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
